// File: hdl/ksp_pkg.sv
// Shared types, constants and arithmetic helpers for the kinematic state predictor.
`timescale 1ns / 1ps
package ksp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS  = 30;
   localparam int PROD_W        = 66;
   localparam int CW            = 34;
   localparam int ZW            = 33;

   localparam logic [30:0] STEP_TIME_RST = 31'd6554;
   localparam logic [30:0] INV_WB_RST    = 31'd24545;

   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [31:0] PI_Q30         = 32'd3373259426;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [7:0] CSR_STEP_TIME     = 8'd0;
   localparam logic [7:0] CSR_INV_WHEELBASE = 8'd1;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] speed;
      logic signed [31:0] track_error;
      logic signed [31:0] heading_error;
      logic signed [31:0] yaw;
      logic signed [31:0] dv;
      logic [1:0]         quad_psi;
      logic [1:0]         quad_eps;
   } side_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = 33'sd843314856;
         1:  r = 33'sd497837829;
         2:  r = 33'sd263043836;
         3:  r = 33'sd133525158;
         4:  r = 33'sd67021686;
         5:  r = 33'sd33543515;
         6:  r = 33'sd16775850;
         7:  r = 33'sd8388437;
         8:  r = 33'sd4194282;
         9:  r = 33'sd2097149;
         10: r = 33'sd1048575;
         11: r = 33'sd524287;
         12: r = 33'sd262143;
         13: r = 33'sd131071;
         14: r = 33'sd65535;
         15: r = 33'sd32767;
         16: r = 33'sd16383;
         17: r = 33'sd8191;
         18: r = 33'sd4095;
         19: r = 33'sd2047;
         20: r = 33'sd1023;
         21: r = 33'sd511;
         22: r = 33'sd255;
         23: r = 33'sd127;
         24: r = 33'sd63;
         25: r = 33'sd31;
         26: r = 33'sd15;
         27: r = 33'sd8;
         28: r = 33'sd4;
         29: r = 33'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > 66'sh7fffffff) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sh80000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/ksp_cordic.sv
// Dual rotation-mode CORDIC pipeline, one iteration per stage, with side data.
`timescale 1ns / 1ps
module ksp_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic signed [ksp_pkg::ZW-1:0] in_z_psi,
   input  logic signed [ksp_pkg::ZW-1:0] in_z_eps,
   input  ksp_pkg::side_type             in_side,
   output logic                          out_vld,
   output logic signed [ksp_pkg::CW-1:0] out_x_psi,
   output logic signed [ksp_pkg::CW-1:0] out_y_psi,
   output logic signed [ksp_pkg::CW-1:0] out_x_eps,
   output logic signed [ksp_pkg::CW-1:0] out_y_eps,
   output ksp_pkg::side_type             out_side
);

   localparam int N = ksp_pkg::CORDIC_STEPS;

   logic                          vld_ff  [0:N];
   logic signed [ksp_pkg::CW-1:0] xp_ff   [0:N];
   logic signed [ksp_pkg::CW-1:0] yp_ff   [0:N];
   logic signed [ksp_pkg::ZW-1:0] zp_ff   [0:N];
   logic signed [ksp_pkg::CW-1:0] xe_ff   [0:N];
   logic signed [ksp_pkg::CW-1:0] ye_ff   [0:N];
   logic signed [ksp_pkg::ZW-1:0] ze_ff   [0:N];
   ksp_pkg::side_type             side_ff [0:N];

   always_comb begin
      vld_ff[0]  = in_vld;
      xp_ff[0]   = ksp_pkg::CORDIC_GAIN_Q30;
      yp_ff[0]   = '0;
      zp_ff[0]   = in_z_psi;
      xe_ff[0]   = ksp_pkg::CORDIC_GAIN_Q30;
      ye_ff[0]   = '0;
      ze_ff[0]   = in_z_eps;
      side_ff[0] = in_side;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [ksp_pkg::ZW-1:0] ANG = ksp_pkg::atan_q30(i);
      logic signed [ksp_pkg::CW-1:0] xp_in, yp_in, xe_in, ye_in;
      logic signed [ksp_pkg::ZW-1:0] zp_in, ze_in;

      always_comb begin
         if (zp_ff[i] >= 0) begin
            xp_in = xp_ff[i] - (yp_ff[i] >>> i);
            yp_in = yp_ff[i] + (xp_ff[i] >>> i);
            zp_in = zp_ff[i] - ANG;
         end else begin
            xp_in = xp_ff[i] + (yp_ff[i] >>> i);
            yp_in = yp_ff[i] - (xp_ff[i] >>> i);
            zp_in = zp_ff[i] + ANG;
         end
         if (ze_ff[i] >= 0) begin
            xe_in = xe_ff[i] - (ye_ff[i] >>> i);
            ye_in = ye_ff[i] + (xe_ff[i] >>> i);
            ze_in = ze_ff[i] - ANG;
         end else begin
            xe_in = xe_ff[i] + (ye_ff[i] >>> i);
            ye_in = ye_ff[i] - (xe_ff[i] >>> i);
            ze_in = ze_ff[i] + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            xp_ff[i+1]   <= xp_in;
            yp_ff[i+1]   <= yp_in;
            zp_ff[i+1]   <= zp_in;
            xe_ff[i+1]   <= xe_in;
            ye_ff[i+1]   <= ye_in;
            ze_ff[i+1]   <= ze_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_vld   = vld_ff[N];
   assign out_x_psi = xp_ff[N];
   assign out_y_psi = yp_ff[N];
   assign out_x_eps = xe_ff[N];
   assign out_y_eps = ye_ff[N];
   assign out_side  = side_ff[N];

endmodule

// File: hdl/kinematic_state_predict.sv
// Top level: one kinematic bicycle model step per request, fully pipelined.
`timescale 1ns / 1ps
// Takes one request per cycle while no result is stalled. A result held on
// rsp_tvalid with rsp_tready low freezes the whole pipeline, and req_tready
// follows it. A request passes a capture stage and three stages of phase,
// reciprocal-scaling and yaw products, then the 30-stage CORDIC, then three
// stages of product, scale and saturating add. Write csr only while no
// request is in flight; csr_ready is always high.
module kinematic_state_predict #(
   parameter int FRAC_BITS = ksp_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, heading, speed, track_error, heading_error, steer_angle, accel
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_pos_x, next_pos_y, next_heading, next_speed, next_track_error,
   // next_heading_error
   output logic [191:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int PW = ksp_pkg::PROD_W;

   logic [30:0] dt_ff, invl_ff;
   logic        adv;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= ksp_pkg::STEP_TIME_RST;
         invl_ff <= ksp_pkg::INV_WB_RST;
      end else if (csr_valid) begin
         if (csr_index == ksp_pkg::CSR_STEP_TIME) begin
            dt_ff <= csr_data[30:0];
         end else if (csr_index == ksp_pkg::CSR_INV_WHEELBASE) begin
            invl_ff <= csr_data[30:0];
         end
      end
   end

   logic signed [PW-1:0] dt_x, invl_x;
   assign dt_x   = PW'($signed({1'b0, dt_ff}));
   assign invl_x = PW'($signed({1'b0, invl_ff}));

   // stage A: capture
   logic               a_vld_ff;
   logic signed [31:0] a_f_ff [0:7];

   // stage B: phase, yaw and speed products
   logic               b_vld_ff;
   logic signed [PW-1:0] b_php_ff, b_phe_ff, b_vd_ff, b_ad_ff;
   ksp_pkg::side_type  b_side_ff;

   // stage C: residual products, second yaw product
   logic               c_vld_ff;
   logic [61:0]        c_rp_ff, c_re_ff;
   logic signed [PW-1:0] c_yaw2_ff;
   ksp_pkg::side_type  c_side_ff;

   // stage D: CORDIC angles, third yaw product
   logic               d_vld_ff;
   logic signed [ksp_pkg::ZW-1:0] d_zp_ff, d_ze_ff;
   logic signed [PW-1:0] d_yaw3_ff;
   ksp_pkg::side_type  d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   logic [31:0] c_php_in, c_phe_in;
   ksp_pkg::side_type b_side_in, c_side_in, d_side_in;
   assign c_php_in = b_php_ff[FRAC_BITS+31:FRAC_BITS];
   assign c_phe_in = b_phe_ff[FRAC_BITS+31:FRAC_BITS];

   always_comb begin
      b_side_in               = '0;
      b_side_in.pos_x         = a_f_ff[0];
      b_side_in.pos_y         = a_f_ff[1];
      b_side_in.heading       = a_f_ff[2];
      b_side_in.speed         = a_f_ff[3];
      b_side_in.track_error   = a_f_ff[4];
      b_side_in.heading_error = a_f_ff[5];
      c_side_in               = b_side_ff;
      c_side_in.dv            = ksp_pkg::sat32(b_ad_ff >>> FRAC_BITS);
      c_side_in.quad_psi      = c_php_in[31:30];
      c_side_in.quad_eps      = c_phe_in[31:30];
      d_side_in               = c_side_ff;
      d_side_in.quad_psi      = c_side_ff.quad_psi;
      d_side_in.quad_eps      = c_side_ff.quad_eps;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++) begin
            a_f_ff[k] <= req_tdata[32*k +: 32];
         end
         b_php_ff  <= PW'(a_f_ff[2]) * PW'($signed({1'b0, ksp_pkg::INV_TWO_PI_Q32}));
         b_phe_ff  <= PW'(a_f_ff[5]) * PW'($signed({1'b0, ksp_pkg::INV_TWO_PI_Q32}));
         b_vd_ff   <= PW'(a_f_ff[3]) * PW'(a_f_ff[6]);
         b_ad_ff   <= PW'(a_f_ff[7]) * dt_x;
         b_side_ff <= b_side_in;

         c_rp_ff   <= 62'(c_php_in[29:0]) * 62'(ksp_pkg::PI_Q30);
         c_re_ff   <= 62'(c_phe_in[29:0]) * 62'(ksp_pkg::PI_Q30);
         c_yaw2_ff <= PW'(ksp_pkg::sat32(b_vd_ff >>> FRAC_BITS)) * invl_x;
         c_side_ff <= c_side_in;

         d_zp_ff   <= ksp_pkg::ZW'(c_rp_ff[61:31]);
         d_ze_ff   <= ksp_pkg::ZW'(c_re_ff[61:31]);
         d_yaw3_ff <= PW'(ksp_pkg::sat32(c_yaw2_ff >>> FRAC_BITS)) * dt_x;
         d_side_ff <= d_side_in;
      end
   end

   ksp_pkg::side_type cor_side_in, cor_side;
   logic              cor_vld;
   logic signed [ksp_pkg::CW-1:0] xp, yp, xe, ye;

   always_comb begin
      cor_side_in     = d_side_ff;
      cor_side_in.yaw = ksp_pkg::sat32(d_yaw3_ff >>> FRAC_BITS);
   end

   ksp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (d_vld_ff),
      .in_z_psi  (d_zp_ff),
      .in_z_eps  (d_ze_ff),
      .in_side   (cor_side_in),
      .out_vld   (cor_vld),
      .out_x_psi (xp),
      .out_y_psi (yp),
      .out_x_eps (xe),
      .out_y_eps (ye),
      .out_side  (cor_side)
   );

   logic signed [ksp_pkg::CW-1:0] cos_psi_in, sin_psi_in, sin_eps_in;

   always_comb begin
      case (cor_side.quad_psi)
         ksp_pkg::QUAD_0: begin cos_psi_in = xp;  sin_psi_in = yp;  end
         ksp_pkg::QUAD_1: begin cos_psi_in = -yp; sin_psi_in = xp;  end
         ksp_pkg::QUAD_2: begin cos_psi_in = -xp; sin_psi_in = -yp; end
         default:         begin cos_psi_in = yp;  sin_psi_in = -xp; end
      endcase
      case (cor_side.quad_eps)
         ksp_pkg::QUAD_0: sin_eps_in = ye;
         ksp_pkg::QUAD_1: sin_eps_in = xe;
         ksp_pkg::QUAD_2: sin_eps_in = -ye;
         default:         sin_eps_in = -xe;
      endcase
   end

   logic                 e_vld_ff, f_vld_ff, g_vld_ff;
   logic signed [PW-1:0] e_px_ff, e_py_ff, e_pe_ff, f_px_ff, f_py_ff, f_pe_ff;
   ksp_pkg::side_type    e_side_ff, f_side_ff;
   logic signed [31:0]   g_out_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= cor_vld;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_px_ff   <= PW'(cor_side.speed) * PW'(cos_psi_in);
         e_py_ff   <= PW'(cor_side.speed) * PW'(sin_psi_in);
         e_pe_ff   <= PW'(cor_side.speed) * PW'(sin_eps_in);
         e_side_ff <= cor_side;

         f_px_ff   <= PW'(ksp_pkg::sat32(e_px_ff >>> 30)) * dt_x;
         f_py_ff   <= PW'(ksp_pkg::sat32(e_py_ff >>> 30)) * dt_x;
         f_pe_ff   <= PW'(ksp_pkg::sat32(e_pe_ff >>> 30)) * dt_x;
         f_side_ff <= e_side_ff;

         g_out_ff[0] <= ksp_pkg::sat32(PW'(f_side_ff.pos_x)
                        + PW'(ksp_pkg::sat32(f_px_ff >>> FRAC_BITS)));
         g_out_ff[1] <= ksp_pkg::sat32(PW'(f_side_ff.pos_y)
                        + PW'(ksp_pkg::sat32(f_py_ff >>> FRAC_BITS)));
         g_out_ff[2] <= ksp_pkg::sat32(PW'(f_side_ff.heading) + PW'(f_side_ff.yaw));
         g_out_ff[3] <= ksp_pkg::sat32(PW'(f_side_ff.speed) + PW'(f_side_ff.dv));
         g_out_ff[4] <= ksp_pkg::sat32(PW'(f_side_ff.track_error)
                        + PW'(ksp_pkg::sat32(f_pe_ff >>> FRAC_BITS)));
         g_out_ff[5] <= ksp_pkg::sat32(PW'(f_side_ff.heading_error) + PW'(f_side_ff.yaw));
      end
   end

   assign rsp_tvalid = g_vld_ff;
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         rsp_tdata[32*k +: 32] = g_out_ff[k];
      end
   end

endmodule

// File: hdl/ksp_checker.sv
// Port-level checks for the kinematic state predictor, bound to the top level.
`timescale 1ns / 1ps
module ksp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic         csr_ready
);

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not track output stall");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind kinematic_state_predict ksp_checker u_ksp_checker (.*);

// File: sim/ksp_checker.sv
// Checker for the kinematic state predictor: predicts each result and compares it.
`timescale 1ns / 1ps
module ksp_scoreboard #(
   parameter int FRAC_BITS = ksp_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [255:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           mismatches,
   output int           outstanding
);

   localparam longint ARCTAN [ksp_pkg::CORDIC_STEPS] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 8, 4, 2};

   logic [30:0]  step_time_q;
   logic [30:0]  inv_wb_q;
   logic [191:0] next_state_q [$];

   string field_name [6] = '{"next_pos_x", "next_pos_y", "next_heading", "next_speed",
                             "next_track_error", "next_heading_error"};

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // cosine and sine in Q30 of a fixed-point angle
   function automatic void rotate(input longint angle, output longint c, output longint s);
      logic [63:0] prod;
      logic [31:0] phase;
      logic [63:0] scaled;
      longint x, y, z, dx, dy;
      prod = angle * 64'sd683565276;
      phase = prod[FRAC_BITS+31 -: 32];
      scaled = {34'd0, phase[29:0]} * 64'd3373259426;
      z = longint'(scaled >> 31);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < ksp_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARCTAN[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARCTAN[i];
         end
      end
      case (phase[31:30])
         ksp_pkg::QUAD_0: begin c = x; s = y; end
         ksp_pkg::QUAD_1: begin c = -y; s = x; end
         ksp_pkg::QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint integrate(input longint base, v, trig, dt);
      longint t;
      t = clamp32((v * trig) >>> 30);
      t = clamp32((t * dt) >>> FRAC_BITS);
      return clamp32(base + t);
   endfunction

   function automatic logic [191:0] bicycle_step(input logic [255:0] d);
      longint px, py, psi, v, cte, epsi, delta, acc, dt, invl;
      longint cpsi, spsi, ceps, seps, yaw, dv;
      longint r [6];
      logic [191:0] o;
      px = $signed(d[31:0]);
      py = $signed(d[63:32]);
      psi = $signed(d[95:64]);
      v = $signed(d[127:96]);
      cte = $signed(d[159:128]);
      epsi = $signed(d[191:160]);
      delta = $signed(d[223:192]);
      acc = $signed(d[255:224]);
      dt = longint'(step_time_q);
      invl = longint'(inv_wb_q);
      rotate(psi, cpsi, spsi);
      rotate(epsi, ceps, seps);
      yaw = clamp32((v * delta) >>> FRAC_BITS);
      yaw = clamp32((yaw * invl) >>> FRAC_BITS);
      yaw = clamp32((yaw * dt) >>> FRAC_BITS);
      dv = clamp32((acc * dt) >>> FRAC_BITS);
      r[0] = integrate(px, v, cpsi, dt);
      r[1] = integrate(py, v, spsi, dt);
      r[2] = clamp32(psi + yaw);
      r[3] = clamp32(v + dv);
      r[4] = integrate(cte, v, seps, dt);
      r[5] = clamp32(epsi + yaw);
      for (int k = 0; k < 6; k++) o[32*k +: 32] = r[k][31:0];
      return o;
   endfunction

   assign outstanding = next_state_q.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      logic [191:0] want;
      if (reset) begin
         step_time_q <= ksp_pkg::STEP_TIME_RST;
         inv_wb_q <= ksp_pkg::INV_WB_RST;
         next_state_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ksp_pkg::CSR_STEP_TIME) step_time_q <= csr_data[30:0];
            else if (csr_index == ksp_pkg::CSR_INV_WHEELBASE) inv_wb_q <= csr_data[30:0];
         end
         if (req_tvalid && req_tready)
            next_state_q.insert(next_state_q.size(), bicycle_step(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (next_state_q.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               mismatches++;
            end else begin
               want = next_state_q.pop_front();
               for (int k = 0; k < 6; k++) begin
                  if (rsp_tdata[32*k +: 32] !== want[32*k +: 32]) begin
                     $error("%s expected %0d got %0d", field_name[k],
                            $signed(want[32*k +: 32]), $signed(rsp_tdata[32*k +: 32]));
                     mismatches++;
                  end
               end
            end
         end
      end
   end

endmodule

// File: sim/tb_kinematic_state_predict.sv
// Testbench top for the kinematic state predictor: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_kinematic_state_predict;

   localparam int DRAIN = 60;
   localparam int PHASE_ITEMS = 240;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;
   int           mismatches;
   int           outstanding;
   int           cycle = 0;

   kinematic_state_predict dut (.*);

   ksp_scoreboard chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cycle <= cycle + 1;

   initial begin
      #5_000_000;
      $display("kinematic_state_predict regression: fail");
      $finish;
   end

   function automatic bit take_break();
      if ((cycle > 30 && cycle < 400) || (cycle > 1500 && cycle < 1900)) return 1'b0;
      return $urandom_range(99) < 13;
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (cycle == 700) hold = 150;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_break();
         end
      end
   end

   task automatic send_request(input logic [255:0] d);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h7fffffff - $urandom_range(3);
         2: return 32'h80000000 + $urandom_range(3);
         default: return $signed($urandom_range(1 << 21)) - (1 << 20);
      endcase
   endfunction

   task automatic random_requests(input int n);
      logic [255:0] d;
      repeat (n) begin
         for (int k = 0; k < 8; k++) d[32*k +: 32] = rand_field();
         send_request(d);
      end
   endtask

   initial begin
      logic [31:0] angles [10] = '{32'd0, 32'd102944, 32'd205887, -32'd102944,
         -32'd205887, 32'd411775, 32'h7fffffff, 32'h80000000, 32'd51472, -32'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and quadrant boundaries of both angles
      send_request('0);
      send_request({8{32'h7fffffff}});
      send_request({8{32'h80000000}});
      send_request({8{32'hffffffff}});
      send_request({8{32'h00000001}});
      for (int i = 0; i < 10; i++)
         send_request({32'd65536, 32'd6554, angles[9 - i], 32'd1000,
                       32'h7fffffff, angles[i], 32'd1000, 32'd1000});
      send_request({32'h80000000, 32'h7fffffff, 32'd0, 32'h80000000,
                    32'h80000000, 32'd0, 32'h7fffffff, 32'h80000000});
      send_request({32'h7fffffff, 32'h80000000, 32'd0, 32'h7fffffff,
                    32'h7fffffff, 32'd0, 32'h80000000, 32'h7fffffff});
      random_requests(PHASE_ITEMS);
      settle();

      write_csr(ksp_pkg::CSR_STEP_TIME, 32'd0);
      write_csr(ksp_pkg::CSR_INV_WHEELBASE, 32'd0);
      random_requests(PHASE_ITEMS);
      settle();

      write_csr(ksp_pkg::CSR_STEP_TIME, 32'hffffffff);
      write_csr(ksp_pkg::CSR_INV_WHEELBASE, 32'h7fffffff);
      write_csr(8'd2, 32'd12345);
      random_requests(PHASE_ITEMS);
      settle();

      write_csr(ksp_pkg::CSR_STEP_TIME, 32'd65536);
      write_csr(ksp_pkg::CSR_INV_WHEELBASE, 32'h80010000);
      write_csr(8'hff, 32'd0);
      random_requests(PHASE_ITEMS);
      settle();

      write_csr(ksp_pkg::CSR_STEP_TIME, $urandom());
      write_csr(ksp_pkg::CSR_INV_WHEELBASE, $urandom_range(200000));
      random_requests(PHASE_ITEMS);
      settle();

      if (mismatches == 0 && outstanding == 0) begin
         $display("kinematic_state_predict regression: pass");
      end else begin
         $display("kinematic_state_predict regression: fail");
      end
      $finish;
   end

endmodule
